### design/frmon_pkg.sv
// Shared types, field widths, command codes and register indexes of the frame sequence monitor.
`default_nettype none

package frmon_pkg;

    // Fixed field widths.
    localparam int CMD_W      = 2;
    localparam int SEQ_W      = 32;
    localparam int BYTES_W    = 32;
    localparam int OFFSET_W   = 48;
    localparam int LOST_W     = 48;
    localparam int COUNT_W    = 32;
    localparam int OUT_TIME_W = 48;
    localparam int SUM_W      = 56;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 1;

    // Fixed part of the input beat: sequence number, byte count and error flag.
    localparam int FRAME_FIXED_W = SEQ_W + BYTES_W + 1;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IDLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_TIMEOUT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BYTES     = 1'b1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] STALL_TIMEOUT_RST = 32'd10000000;
    localparam logic [CFG_W-1:0] MAX_BYTES_RST     = 32'd4194304;

    // Result beat layout, lowest field first.
    localparam int OUT_OFFSET_LSB  = 0;
    localparam int OUT_WRITTEN_BIT = OUT_OFFSET_LSB + OFFSET_W;
    localparam int OUT_GAP_BIT     = OUT_WRITTEN_BIT + 1;
    localparam int OUT_MISSING_LSB = OUT_GAP_BIT + 1;
    localparam int OUT_DELTA_LSB   = OUT_MISSING_LSB + SEQ_W;
    localparam int OUT_STALLED_BIT = OUT_DELTA_LSB + OUT_TIME_W;
    localparam int OUT_LOST_LSB    = OUT_STALLED_BIT + 1;
    localparam int OUT_ERROR_LSB   = OUT_LOST_LSB + LOST_W;
    localparam int OUT_COUNT_LSB   = OUT_ERROR_LSB + COUNT_W;
    localparam int OUT_MIN_LSB     = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_MAX_LSB     = OUT_MIN_LSB + OUT_TIME_W;
    localparam int OUT_SUM_LSB     = OUT_MAX_LSB + OUT_TIME_W;
    localparam int OUT_FIELDS_W    = OUT_SUM_LSB + SUM_W;
    localparam int M_TDATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Window update controls from the item stage.
    typedef struct packed {
        logic add;
        logic clear;
    } win_ctrl_t;

endpackage

`default_nettype wire

### design/frame_sequence_monitor.sv
// Top level of the frame sequence monitor: item register, per-item update and result register.
`default_nettype none

// The monitor takes one beat per clock while m_tready stays high and presents one result beat
// for each. The beat is captured in an input register. All counters, the interval
// window and the stall flag are updated by one pass of compares and additions. The result
// lands in an output register that holds while m_tready is low. While a result waits, the
// input register can still take one more beat, and then s_tready drops. With m_tready high
// the sustained rate is one beat per cycle, set by the single update pass against the state
// registers. s_tuser carries the command (frame, idle check, clear window). Configuration
// writes take effect at once and are meant for idle periods.
module frame_sequence_monitor #(
    parameter int TIME_WIDTH = 48
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input beats.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // s_tdata, from bit 0: now_us, sequence_req, timestamp_us, byte_count, error_flag.
    input  wire logic [((2*TIME_WIDTH+frmon_pkg::FRAME_FIXED_W+7)/8)*8-1:0] s_tdata,
    // s_tuser: cmd.
    input  wire logic [frmon_pkg::CMD_W-1:0]            s_tuser,
    // Result beats.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata, from bit 0: record_offset, frame_written, gap_found, missing_frames,
    // delta_us, stalled, lost_total, error_total, window_count, window_min_us,
    // window_max_us, window_sum_us, zero fill.
    output logic      [frmon_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration writes.
    input  wire logic                                  cfg_wr_en,
    input  wire logic [frmon_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [frmon_pkg::CFG_W-1:0]            cfg_wr_data
);
    import frmon_pkg::*;

    localparam int NOW_LSB   = 0;
    localparam int SEQ_LSB   = NOW_LSB + TIME_WIDTH;
    localparam int TS_LSB    = SEQ_LSB + SEQ_W;
    localparam int BYTES_LSB = TS_LSB + TIME_WIDTH;
    localparam int ERR_BIT   = BYTES_LSB + BYTES_W;

    // Configuration registers.
    logic [CFG_W-1:0] stall_timeout_reg;
    logic [CFG_W-1:0] max_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_timeout_reg <= STALL_TIMEOUT_RST;
            max_bytes_reg     <= MAX_BYTES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STALL_TIMEOUT: stall_timeout_reg <= cfg_wr_data;
                REG_MAX_BYTES:     max_bytes_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input register and handshake.
    logic                  in_valid_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [TIME_WIDTH-1:0] ts_reg;
    logic [BYTES_W-1:0]    bytes_reg;
    logic                  err_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic                  advance;
    logic                  in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg   <= s_tuser;
            now_reg   <= s_tdata[NOW_LSB +: TIME_WIDTH];
            seq_reg   <= s_tdata[SEQ_LSB +: SEQ_W];
            ts_reg    <= s_tdata[TS_LSB +: TIME_WIDTH];
            bytes_reg <= s_tdata[BYTES_LSB +: BYTES_W];
            err_reg   <= s_tdata[ERR_BIT];
        end
    end

    // Stream state.
    logic                  have_first_reg;
    logic [SEQ_W-1:0]      prev_seq_reg;
    logic [TIME_WIDTH-1:0] prev_ts_reg;
    logic [TIME_WIDTH-1:0] last_arrival_reg;
    logic [OFFSET_W-1:0]   write_offset_reg, write_offset_next;
    logic [LOST_W-1:0]     lost_reg, lost_next;
    logic [COUNT_W-1:0]    error_reg, error_next;
    logic                  stall_reg, stall_next;

    // Per-item decode.
    logic                  is_frame;
    logic                  is_idle;
    logic                  is_clear;
    logic [SEQ_W-1:0]      missing_raw;
    logic                  gap;
    logic                  ts_fwd;
    logic [TIME_WIDTH-1:0] delta;
    logic [LOST_W:0]       lost_sum;
    logic                  size_ok;
    logic [OFFSET_W:0]     offset_sum;
    logic [TIME_WIDTH-1:0] idle_time;
    logic                  stall_hit;

    assign is_frame = (cmd_reg == CMD_FRAME);
    assign is_idle  = (cmd_reg == CMD_IDLE);
    assign is_clear = (cmd_reg == CMD_CLEAR);

    // Sequence gap with 32-bit wrap; a gap is any number missing but zero.
    assign missing_raw = seq_reg - prev_seq_reg - 1'b1;
    assign gap         = is_frame && have_first_reg && (missing_raw != '0);
    assign lost_sum    = {1'b0, lost_reg} + (LOST_W + 1)'(missing_raw);

    // Only a forward timestamp gives an interval.
    assign ts_fwd = is_frame && have_first_reg && (ts_reg > prev_ts_reg);
    assign delta  = ts_fwd ? ts_reg - prev_ts_reg : '0;

    // Byte offset advances only for frames of valid size.
    assign size_ok    = (bytes_reg != '0) && (bytes_reg <= max_bytes_reg);
    assign offset_sum = {1'b0, write_offset_reg} + (OFFSET_W + 1)'(bytes_reg);

    // Stall when the idle time since the last frame exceeds the timeout.
    assign idle_time = now_reg - last_arrival_reg;
    assign stall_hit = (now_reg > last_arrival_reg) &&
                       (idle_time > TIME_WIDTH'(stall_timeout_reg));

    always_comb begin
        lost_next         = lost_reg;
        error_next        = error_reg;
        write_offset_next = write_offset_reg;
        stall_next        = stall_reg;
        if (gap) begin
            lost_next = lost_sum[LOST_W] ? {LOST_W{1'b1}} : lost_sum[LOST_W-1:0];
        end
        if (is_frame && err_reg && (error_reg != {COUNT_W{1'b1}})) begin
            error_next = error_reg + 1'b1;
        end
        if (is_frame && size_ok) begin
            write_offset_next = offset_sum[OFFSET_W] ? {OFFSET_W{1'b1}}
                                                     : offset_sum[OFFSET_W-1:0];
        end
        if (is_idle && stall_hit) begin
            stall_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg   <= 1'b0;
            prev_seq_reg     <= '0;
            prev_ts_reg      <= '0;
            last_arrival_reg <= '0;
            write_offset_reg <= '0;
            lost_reg         <= '0;
            error_reg        <= '0;
            stall_reg        <= 1'b0;
        end else if (advance) begin
            write_offset_reg <= write_offset_next;
            lost_reg         <= lost_next;
            error_reg        <= error_next;
            stall_reg        <= stall_next;
            if (is_frame) begin
                have_first_reg   <= 1'b1;
                prev_seq_reg     <= seq_reg;
                prev_ts_reg      <= ts_reg;
                last_arrival_reg <= now_reg;
            end
        end
    end

    // Interval window.
    win_ctrl_t             win_ctrl;
    logic [COUNT_W-1:0]    win_count;
    logic [OUT_TIME_W-1:0] win_min;
    logic [OUT_TIME_W-1:0] win_max;
    logic [SUM_W-1:0]      win_sum;

    assign win_ctrl.add   = advance && ts_fwd;
    assign win_ctrl.clear = advance && is_clear;

    frmon_window #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .delta     (delta),
        .rpt_count (win_count),
        .rpt_min   (win_min),
        .rpt_max   (win_max),
        .rpt_sum   (win_sum)
    );

    // Result beat assembly.
    logic [OFFSET_W-1:0]  rec_offset;
    logic                 written;
    logic [SEQ_W-1:0]     missing;
    logic [M_TDATA_W-1:0] result;

    assign rec_offset = is_frame ? write_offset_reg : '0;
    assign written    = is_frame && size_ok;
    assign missing    = gap ? missing_raw : '0;

    assign result = {
        {(M_TDATA_W - OUT_FIELDS_W){1'b0}},
        win_sum,
        win_max,
        win_min,
        win_count,
        error_next,
        lost_next,
        stall_next,
        OUT_TIME_W'(delta),
        missing,
        gap,
        written,
        rec_offset
    };

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### design/frmon_window.sv
// Interval window statistics: count, minimum, maximum and saturating sum.
`default_nettype none

module frmon_window #(
    parameter int TIME_WIDTH = 48
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire frmon_pkg::win_ctrl_t            ctrl,
    input  wire logic [TIME_WIDTH-1:0]           delta,
    output logic      [frmon_pkg::COUNT_W-1:0]    rpt_count,
    output logic      [frmon_pkg::OUT_TIME_W-1:0] rpt_min,
    output logic      [frmon_pkg::OUT_TIME_W-1:0] rpt_max,
    output logic      [frmon_pkg::SUM_W-1:0]      rpt_sum
);
    import frmon_pkg::*;

    localparam int SUMX_W = ((SUM_W > TIME_WIDTH) ? SUM_W : TIME_WIDTH) + 1;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [TIME_WIDTH-1:0] min_reg, min_next;
    logic [TIME_WIDTH-1:0] max_reg, max_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SUMX_W-1:0]     sum_wide;
    logic [SUM_W-1:0]      sum_sat;
    logic [COUNT_W-1:0]    count_inc;

    // Saturating updates for one new interval.
    assign sum_wide  = SUMX_W'(sum_reg) + SUMX_W'(delta);
    assign sum_sat   = (sum_wide > SUMX_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign count_inc = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    // A clear empties the whole window, maximum included.
    always_comb begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        if (ctrl.clear) begin
            count_next = '0;
            min_next   = '0;
            max_next   = '0;
            sum_next   = '0;
        end else if (ctrl.add) begin
            if (count_reg == '0 || delta < min_reg) begin
                min_next = delta;
            end
            if (delta > max_reg) begin
                max_next = delta;
            end
            sum_next   = sum_sat;
            count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
        end
    end

    // Report the window as it stands after this item; extremes read 0 when empty.
    assign rpt_count = count_next;
    assign rpt_min   = (count_next != '0) ? OUT_TIME_W'(min_next) : '0;
    assign rpt_max   = (count_next != '0) ? OUT_TIME_W'(max_next) : '0;
    assign rpt_sum   = sum_next;

endmodule

`default_nettype wire

### design/frmon_checker.sv
// Port-level checks of the frame sequence monitor and their binding to the top level.
`default_nettype none

module frmon_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [frmon_pkg::M_TDATA_W-1:0] m_tdata
);
    import frmon_pkg::*;

    logic                  stalled;
    logic                  gap;
    logic [SEQ_W-1:0]      missing;
    logic [COUNT_W-1:0]    count;
    logic [OUT_TIME_W-1:0] wmin;
    logic [OUT_TIME_W-1:0] wmax;

    assign stalled = m_tdata[OUT_STALLED_BIT];
    assign gap     = m_tdata[OUT_GAP_BIT];
    assign missing = m_tdata[OUT_MISSING_LSB +: SEQ_W];
    assign count   = m_tdata[OUT_COUNT_LSB +: COUNT_W];
    assign wmin    = m_tdata[OUT_MIN_LSB +: OUT_TIME_W];
    assign wmax    = m_tdata[OUT_MAX_LSB +: OUT_TIME_W];

    // A stalled result beat holds its data until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Once a beat reports a stall, every later beat does too.
    a_stall_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && stalled |=> !m_tvalid || stalled)
        else $error("stall flag dropped");

    // A gap is reported exactly when frames are missing.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> gap == (missing != '0))
        else $error("gap flag disagrees with missing count");

    // An empty window shows zero extremes.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && count == '0 |-> wmin == '0 && wmax == '0)
        else $error("empty window shows nonzero extremes");

endmodule

bind frame_sequence_monitor frmon_checker u_frmon_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
